@@ rtl/assert_macros.svh @@
// assertion macros shared by the bellman-ford core modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define BFSP_ASSERT(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("bfsp assertion failed");

// same-cycle implication
`define BFSP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bfsp assertion failed");

// next-cycle implication
`define BFSP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bfsp assertion failed");

`endif

@@ rtl/bfsp_pkg.sv @@
// shared types and constants of the bellman-ford shortest path core
// no dependencies
package bfsp_pkg;

  localparam int CMD_W    = 2;
  localparam int VCOUNT_W = 7;
  localparam int DIST_W   = 32;

  // input commands
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

  // register map, index of each register
  localparam int REG_VERTEX_COUNT = 0;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fff_ffff;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

  // source of the distance store write data
  typedef enum logic [1:0] {
    DW_CLEAR,
    DW_SOURCE,
    DW_RELAX
  } dwr_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     edge_we;
    logic     dist_we;
    dwr_sel_e dist_wsel;
    logic     rd_out;
    logic     out_load;
    logic     out_last;
    logic     flag_clr;
    logic     flag_chk;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fall;
    logic out_free;
  } dp_sts_t;

endpackage

@@ rtl/bfsp_in_if.sv @@
// input channel of the bellman-ford core: commands, edges and run requests
// depends on bfsp_pkg
interface bfsp_in_if #(
  parameter int VW = 6,
  parameter int WB = 16
);
  logic                        valid;
  logic                        ready;
  logic [bfsp_pkg::CMD_W-1:0]  cmd;
  logic [VW-1:0]               edge_from;
  logic [VW-1:0]               edge_to;
  logic signed [WB-1:0]        edge_weight;
  logic [VW-1:0]               source_vertex;

  modport source (output valid, cmd, edge_from, edge_to, edge_weight, source_vertex,
                  input ready);
  modport sink   (input valid, cmd, edge_from, edge_to, edge_weight, source_vertex,
                  output ready);
endinterface

@@ rtl/bfsp_out_if.sv @@
// result channel of the bellman-ford core: one word per vertex of a run
// depends on bfsp_pkg
interface bfsp_out_if #(
  parameter int VW = 6
);
  logic                               valid;
  logic                               ready;
  logic [VW-1:0]                      vertex;
  logic signed [bfsp_pkg::DIST_W-1:0] distance;
  logic                               reachable;
  logic                               negative_cycle;
  logic                               last;

  modport source (output valid, vertex, distance, reachable, negative_cycle, last,
                  input ready);
  modport sink   (input valid, vertex, distance, reachable, negative_cycle, last,
                  output ready);
endinterface

@@ rtl/bfsp_ram.sv @@
// generic ram: one write port, two read ports with registered read data
// no dependencies
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule

@@ rtl/bfsp_ctrl.sv @@
// controller of the bellman-ford core: command decode, sweep and pass sequencing
// depends on bfsp_pkg and assert_macros.svh
`include "assert_macros.svh"
module bfsp_ctrl #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [bfsp_pkg::CMD_W-1:0]            in_cmd_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]       in_src_i,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]     n_i,
  input  bfsp_pkg::dp_sts_t                     sts_i,
  output bfsp_pkg::dp_cmd_t                     cmd_o,
  output logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] edge_waddr_o,
  output logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] edge_raddr_o,
  output logic [$clog2(MAX_VERTICES)-1:0]       vidx_o,
  output logic [$clog2(MAX_VERTICES+1)-1:0]     n_o
);
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = EAW + 1;
  localparam logic [ETW-1:0] ETOT_MAX = ETW'(MAX_EDGES);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_SOURCE = 3'd2;
  localparam logic [2:0] ST_PASS   = 3'd3;
  localparam logic [2:0] ST_LOOKUP = 3'd4;
  localparam logic [2:0] ST_RELAX  = 3'd5;
  localparam logic [2:0] ST_OUT_RD = 3'd6;
  localparam logic [2:0] ST_OUT_LD = 3'd7;

  logic [2:0]     state_q, state_d;
  logic [ETW-1:0] etot_q, etot_d;
  logic [ETW-1:0] e_q, e_d;
  logic [NW-1:0]  n_q, n_d;
  logic [NW-1:0]  v_q, v_d;
  logic [NW-1:0]  p_q, p_d;
  logic [VW-1:0]  src_q, src_d;
  logic           chk_q, chk_d;
  logic           accept;
  logic           src_in_rng;
  logic           v_last;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign src_in_rng = NW'(src_q) < n_q;
  assign v_last     = (v_q == n_q - NW'(1));

  assign edge_waddr_o = etot_q[EAW-1:0];
  assign edge_raddr_o = e_q[EAW-1:0];
  assign vidx_o       = (state_q == ST_SOURCE) ? src_q : v_q[VW-1:0];
  assign n_o          = n_q;

  always_comb begin
    state_d = state_q;
    etot_d  = etot_q;
    e_d     = e_q;
    n_d     = n_q;
    v_d     = v_q;
    p_d     = p_q;
    src_d   = src_q;
    chk_d   = chk_q;
    cmd_o   = '0;
    cmd_o.dist_wsel = bfsp_pkg::DW_CLEAR;
    cmd_o.out_last  = v_last;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            bfsp_pkg::CMD_ADD: begin
              if (etot_q != ETOT_MAX) begin
                cmd_o.edge_we = 1'b1;
                etot_d        = etot_q + ETW'(1);
              end
            end
            bfsp_pkg::CMD_CLEAR: begin
              etot_d = '0;
            end
            bfsp_pkg::CMD_RUN: begin
              cmd_o.flag_clr = 1'b1;
              n_d     = n_i;
              src_d   = in_src_i;
              v_d     = '0;
              state_d = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.dist_we   = 1'b1;
        cmd_o.dist_wsel = bfsp_pkg::DW_CLEAR;
        v_d = v_q + NW'(1);
        if (v_last) begin
          if (src_in_rng) begin
            state_d = ST_SOURCE;
          end else begin
            v_d     = '0;
            state_d = ST_OUT_RD;
          end
        end
      end
      ST_SOURCE: begin
        cmd_o.dist_we   = 1'b1;
        cmd_o.dist_wsel = bfsp_pkg::DW_SOURCE;
        e_d     = '0;
        p_d     = '0;
        chk_d   = (n_q == NW'(1));
        state_d = ST_PASS;
      end
      ST_PASS: begin
        if (e_q == etot_q) begin
          e_d = '0;
          if (chk_q) begin
            v_d     = '0;
            state_d = ST_OUT_RD;
          end else begin
            p_d   = p_q + NW'(1);
            chk_d = (p_q + NW'(1) == n_q - NW'(1));
          end
        end else begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_RELAX;
      end
      ST_RELAX: begin
        cmd_o.dist_we   = !chk_q;
        cmd_o.dist_wsel = bfsp_pkg::DW_RELAX;
        cmd_o.flag_chk  = chk_q;
        e_d = e_q + ETW'(1);
        if (chk_q && sts_i.fall) begin
          v_d     = '0;
          state_d = ST_OUT_RD;
        end else begin
          state_d = ST_PASS;
        end
      end
      ST_OUT_RD: begin
        cmd_o.rd_out = 1'b1;
        state_d      = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        cmd_o.rd_out   = 1'b1;
        cmd_o.out_load = 1'b1;
        if (sts_i.out_free) begin
          v_d     = v_q + NW'(1);
          state_d = v_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      etot_q  <= '0;
      e_q     <= '0;
      n_q     <= NW'(1);
      v_q     <= '0;
      p_q     <= '0;
      src_q   <= '0;
      chk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      etot_q  <= etot_d;
      e_q     <= e_d;
      n_q     <= n_d;
      v_q     <= v_d;
      p_q     <= p_d;
      src_q   <= src_d;
      chk_q   <= chk_d;
    end
  end

  `BFSP_ASSERT(a_etot_bound, etot_q <= ETOT_MAX)
  `BFSP_ASSERT_IMP(a_relax_after_lookup, state_q == ST_RELAX, $past(state_q) == ST_LOOKUP)
  `BFSP_ASSERT_IMP(a_pass_bound, state_q == ST_PASS, p_q < n_q)
  `BFSP_ASSERT_IMP(a_edge_bound, state_q == ST_LOOKUP, e_q < etot_q)
endmodule

@@ rtl/bfsp_dp.sv @@
// datapath of the bellman-ford core: edge and distance stores, relax unit, result register
// depends on bfsp_pkg, bfsp_ram and assert_macros.svh
`include "assert_macros.svh"
module bfsp_dp #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bfsp_pkg::dp_cmd_t                     cmd_i,
  output bfsp_pkg::dp_sts_t                     sts_o,
  input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] edge_waddr_i,
  input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] edge_raddr_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]       vidx_i,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]     n_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]       in_from_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]       in_to_i,
  input  logic signed [WEIGHT_BITS-1:0]         in_weight_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [$clog2(MAX_VERTICES)-1:0]       out_vertex_o,
  output logic signed [bfsp_pkg::DIST_W-1:0]    out_distance_o,
  output logic                                  out_reachable_o,
  output logic                                  out_neg_o,
  output logic                                  out_last_o
);
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EDW = 2 * VW + WEIGHT_BITS;
  localparam int DW  = bfsp_pkg::DIST_W;

  logic [EDW-1:0]        edge_rd;
  logic [VW-1:0]         e_from, e_to;
  logic signed [WEIGHT_BITS-1:0] e_w;

  logic                  dist_we;
  logic [VW-1:0]         dist_waddr, dist_raddr_a;
  logic [DW:0]           dist_wdata, dist_rd_a, dist_rd_b;
  logic                  reach_a, reach_b;
  logic signed [DW-1:0]  da, db;
  logic signed [DW:0]    sum;
  logic signed [DW-1:0]  cand;
  logic                  in_rng, fall;

  logic                  flag_q;
  logic                  out_valid_q;
  logic [VW-1:0]         out_vertex_q;
  logic signed [DW-1:0]  out_dist_q;
  logic                  out_reach_q, out_neg_q, out_last_q;
  logic                  out_free, out_take;

  // edge store, one word per edge: start, end, weight
  bfsp_ram #(
    .WIDTH(EDW),
    .DEPTH(1 << EAW)
  ) u_edge_ram (
    .clk_i    (clk_i),
    .we_i     (cmd_i.edge_we),
    .waddr_i  (edge_waddr_i),
    .wdata_i  ({in_from_i, in_to_i, in_weight_i}),
    .raddr_a_i(edge_raddr_i),
    .rdata_a_o(edge_rd),
    .raddr_b_i(edge_raddr_i),
    .rdata_b_o()
  );

  assign e_from = edge_rd[EDW-1 -: VW];
  assign e_to   = edge_rd[WEIGHT_BITS +: VW];
  assign e_w    = signed'(edge_rd[WEIGHT_BITS-1:0]);

  // distance store with reached bit on top
  bfsp_ram #(
    .WIDTH(DW + 1),
    .DEPTH(1 << VW)
  ) u_dist_ram (
    .clk_i    (clk_i),
    .we_i     (dist_we),
    .waddr_i  (dist_waddr),
    .wdata_i  (dist_wdata),
    .raddr_a_i(dist_raddr_a),
    .rdata_a_o(dist_rd_a),
    .raddr_b_i(e_to),
    .rdata_b_o(dist_rd_b)
  );

  assign dist_raddr_a = cmd_i.rd_out ? vidx_i : e_from;
  assign reach_a = dist_rd_a[DW];
  assign reach_b = dist_rd_b[DW];
  assign da      = signed'(dist_rd_a[DW-1:0]);
  assign db      = signed'(dist_rd_b[DW-1:0]);

  // relax: saturating add then compare
  always_comb begin
    sum = (DW+1)'(da) + (DW+1)'(e_w);
    if (sum[DW] != sum[DW-1]) begin
      cand = sum[DW] ? bfsp_pkg::DIST_MIN : bfsp_pkg::DIST_MAX;
    end else begin
      cand = sum[DW-1:0];
    end
  end

  assign in_rng = (NW'(e_from) < n_i) && (NW'(e_to) < n_i);
  assign fall   = in_rng && reach_a && (!reach_b || (cand < db));

  always_comb begin
    dist_waddr = vidx_i;
    dist_wdata = '0;
    case (cmd_i.dist_wsel)
      bfsp_pkg::DW_CLEAR: begin
        dist_wdata = '0;
      end
      bfsp_pkg::DW_SOURCE: begin
        dist_wdata = {1'b1, {DW{1'b0}}};
      end
      bfsp_pkg::DW_RELAX: begin
        dist_waddr = e_to;
        dist_wdata = {1'b1, cand};
      end
      default: begin
      end
    endcase
  end

  assign dist_we = cmd_i.dist_we && ((cmd_i.dist_wsel != bfsp_pkg::DW_RELAX) || fall);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (cmd_i.flag_clr) begin
      flag_q <= 1'b0;
    end else if (cmd_i.flag_chk && fall) begin
      flag_q <= 1'b1;
    end
  end

  // result register
  assign out_take = out_valid_q && out_ready_i;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load && out_free) begin
      out_vertex_q <= vidx_i;
      out_dist_q   <= reach_a ? da : '0;
      out_reach_q  <= reach_a;
      out_neg_q    <= flag_q;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign sts_o.fall     = fall;
  assign sts_o.out_free = out_free;

  assign out_valid_o     = out_valid_q;
  assign out_vertex_o    = out_vertex_q;
  assign out_distance_o  = out_dist_q;
  assign out_reachable_o = out_reach_q;
  assign out_neg_o       = out_neg_q;
  assign out_last_o      = out_last_q;

  `BFSP_ASSERT_IMP(a_check_no_write, cmd_i.flag_chk, !cmd_i.dist_we)
  `BFSP_ASSERT_IMP(a_unreached_zero, out_valid_q && !out_reach_q, out_dist_q == '0)
endmodule

@@ rtl/bellman_ford_shortest_paths_core.sv @@
// bellman-ford shortest path core: top level with register port and channel wiring
// depends on bfsp_pkg, bfsp_in_if, bfsp_out_if, bfsp_ctrl and bfsp_dp
//
// The core holds a directed edge list of up to MAX_EDGES signed edges. An add word
// appends one edge (dropped once the list is full), a clear word empties the list;
// both return nothing. A run word starts from source_vertex with n = vertex_count
// vertices (0 acts as 1, values above MAX_VERTICES act as MAX_VERTICES) and returns
// n result words, vertex 0 first, last set on the final one. Edges touching a vertex
// at or above n are ignored, and distances saturate at 32 bits. A run sweeps the
// distance store clear one vertex at a time, seeds the source (a source at or above
// n skips to the results), then makes n-1 relaxation passes over the edges loaded
// and one check pass that stops at the first edge that still relaxes, then sends one
// result word at a time, held by any output stall. Each edge goes through the edge
// store read, the distance store read and the add, compare and write back, one edge
// at a time since each edge may see the distance the previous one wrote. No new
// word is taken until the last result of a run sits in the output register.
// vertex_count is at byte address 0 of the register port, reset value 64.
module bellman_ford_shortest_paths_core #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfsp_in_if.sink     in_if,
  bfsp_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW  = bfsp_pkg::VCOUNT_W;
  localparam logic [NW-1:0] NMAX = NW'(MAX_VERTICES);

  logic [CW-1:0]      vcount_q;
  logic               reg_hit;
  logic [NW-1:0]      n_run;
  bfsp_pkg::dp_cmd_t  dp_cmd;
  bfsp_pkg::dp_sts_t  dp_sts;
  logic [EAW-1:0]     edge_waddr, edge_raddr;
  logic [VW-1:0]      vidx;
  logic [NW-1:0]      n_cur;

  // register port, word index is paddr[2]
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'(bfsp_pkg::REG_VERTEX_COUNT));
  assign prdata  = reg_hit ? {{(32-CW){1'b0}}, vcount_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= bfsp_pkg::VCOUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      vcount_q <= pwdata[CW-1:0];
    end
  end

  // vertex count in use for the next run, clamped to 1..MAX_VERTICES
  always_comb begin
    if (vcount_q == '0) begin
      n_run = NW'(1);
    end else if (32'(vcount_q) > 32'(MAX_VERTICES)) begin
      n_run = NMAX;
    end else begin
      n_run = NW'(vcount_q);
    end
  end

  bfsp_ctrl #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_cmd_i    (in_if.cmd),
    .in_src_i    (in_if.source_vertex),
    .n_i         (n_run),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd),
    .edge_waddr_o(edge_waddr),
    .edge_raddr_o(edge_raddr),
    .vidx_o      (vidx),
    .n_o         (n_cur)
  );

  bfsp_dp #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .sts_o          (dp_sts),
    .edge_waddr_i   (edge_waddr),
    .edge_raddr_i   (edge_raddr),
    .vidx_i         (vidx),
    .n_i            (n_cur),
    .in_from_i      (in_if.edge_from),
    .in_to_i        (in_if.edge_to),
    .in_weight_i    (in_if.edge_weight),
    .out_ready_i    (out_if.ready),
    .out_valid_o    (out_if.valid),
    .out_vertex_o   (out_if.vertex),
    .out_distance_o (out_if.distance),
    .out_reachable_o(out_if.reachable),
    .out_neg_o      (out_if.negative_cycle),
    .out_last_o     (out_if.last)
  );
endmodule
